// File: hdl/rpn_pkg.sv
// Package for the RPN expression evaluator: character codes, operator codes,
// status codes, second-stage action codes and the stage control struct.
// No dependencies; used by rpn_alu and rpn_expression_evaluator_top.
package rpn_pkg;

   // Character codes of the expression stream.
   localparam logic [7:0] CH_END   = 8'd0;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_EQ    = 8'd61;

   // Digit weight of the decimal accumulator.
   localparam logic [31:0] RADIX = 32'd10;

   // Operator codes of the arithmetic unit.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_SUB = 2'd2;

   // Status codes reported with each result.
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_UNDER = 2'd1;
   localparam logic [1:0] ERR_OVER  = 2'd2;

   // Actions carried out by the second stage on the top-of-stack register.
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_PUSH    = 3'd1;
   localparam logic [2:0] ACT_PUSH_OP = 3'd2;
   localparam logic [2:0] ACT_OP      = 3'd3;
   localparam logic [2:0] ACT_END     = 3'd4;

   // Control handed from the decode stage to the execute stage.
   typedef struct packed {
      logic [2:0] act;     // action code
      logic [1:0] op;      // operator code
      logic       wen;     // spill the old top into the stack memory
      logic       fwd;     // second operand comes from the bypass register
      logic       pushed;  // end transaction pushed a pending number
      logic       empty;   // end transaction found an empty stack
      logic [1:0] status;  // status to report on an end transaction
   } stage_ctrl_type;

endpackage

// File: hdl/rpn_expression_evaluator_top.sv
// Top level of the RPN expression evaluator.
// Depends on rpn_pkg and rpn_alu.
//
// Usage: the req channel carries one ASCII character per transaction
// (req_char_code). Digits build an unsigned 32-bit number, any other
// character except '=' pushes a pending number, and '+', '*', '-' combine
// the two top operands. The character 0 ends the expression: one rsp
// transaction follows with the top of stack (rsp_value, 0 if empty) and
// the first error seen (rsp_status: 0 ok, 1 underflow, 2 overflow).
// Throughput is one character per cycle while req_ready is high. A character
// is decoded and the stack count updated as it is accepted; the decoded
// control is registered for the execute stage, which updates the top-of-stack
// register and the stack memory (one read and one write port, read data
// registered) and loads the end result into the rsp register once it is free.
// Only one memory entry is read per operator because the top lives in a
// register; a spill write and a read of the same entry are bypassed.
// A result waits in the rsp register while the receiver stalls; input
// keeps flowing until a second end character reaches the execute stage
// while the first result is still held. req_ready then stays low until the
// cycle after the held result is taken.
// Reset clears the accumulator, stack count, error, the execute-stage control
// and the result valid flag; the stack memory needs no clearing.
module rpn_expression_evaluator_top #(
   parameter int STACK_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   // Decode-stage state.
   logic [31:0]   accum_ff, accum_in;
   logic          digit_ff, digit_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    err_ff, err_in;

   // Execute-stage state.
   rpn_pkg::stage_ctrl_type b_ctrl_ff, b_ctrl_in, dec_ctrl;
   logic [31:0]   b_val_ff;
   logic [AW-1:0] b_waddr_ff;
   logic [31:0]   tos_ff, tos_in;
   logic [31:0]   rd_data_ff;
   logic [31:0]   fwd_data_ff;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff;
   logic [1:0]    rsp_status_ff;

   // Stack memory: entries below the top of stack.
   logic [31:0]   stack_mem [STACK_DEPTH];

   logic          acc;
   logic          is_digit, is_op, is_end;
   logic          push_try, push_ok, op_ok, ovf, unf;
   logic [CW-1:0] c1;
   logic [1:0]    e1, e2;
   logic [1:0]    op_code;
   logic [31:0]   digit_val;
   logic          rd_en, mem_we;
   logic [AW-1:0] raddr, waddr;
   logic          b_stall;
   logic [31:0]   second, alu_lhs, alu_rhs, alu_res;

   // Handshake: the input stalls only while an end sits behind a held result.
   assign b_stall   = (b_ctrl_ff.act == rpn_pkg::ACT_END) && rsp_valid_ff;
   assign req_ready = !b_stall;
   assign acc       = req_valid && req_ready;

   // Character classification.
   always_comb begin
      is_digit = req_char_code inside {[rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]};
      is_op    = req_char_code inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_STAR,
                                       rpn_pkg::CH_MINUS};
      is_end   = (req_char_code == rpn_pkg::CH_END);
      case (req_char_code)
         rpn_pkg::CH_PLUS: op_code = rpn_pkg::OP_ADD;
         rpn_pkg::CH_STAR: op_code = rpn_pkg::OP_MUL;
         default:          op_code = rpn_pkg::OP_SUB;
      endcase
   end

   // Stack pointer and error bookkeeping for one character.
   always_comb begin
      push_try = !is_digit && digit_ff && (req_char_code != rpn_pkg::CH_EQ);
      push_ok  = push_try && (count_ff < DEPTH_C);
      c1       = count_ff + (push_ok ? ONE_C : '0);
      op_ok    = is_op && (c1 >= TWO_C);
      ovf      = push_try && !push_ok;
      unf      = is_op && !op_ok;
      e1       = (err_ff == rpn_pkg::ERR_NONE && ovf) ? rpn_pkg::ERR_OVER : err_ff;
      e2       = (e1 == rpn_pkg::ERR_NONE && unf) ? rpn_pkg::ERR_UNDER : e1;
      digit_val = 32'(req_char_code - rpn_pkg::CH_ZERO);
   end

   // Memory addresses: spill slot for a push, second operand for an operator.
   assign waddr  = AW'(count_ff - ONE_C);
   assign raddr  = AW'(count_ff - TWO_C);
   assign rd_en  = acc && op_ok && !push_ok;
   assign mem_we = b_ctrl_ff.wen;

   // Control for the execute stage.
   always_comb begin
      dec_ctrl        = '0;
      dec_ctrl.op     = op_code;
      dec_ctrl.status = e2;
      dec_ctrl.pushed = push_ok;
      dec_ctrl.empty  = (c1 == '0);
      dec_ctrl.wen    = push_ok && !op_ok && !is_end && (count_ff != '0);
      dec_ctrl.fwd    = mem_we && (b_waddr_ff == raddr);
      if (is_end) begin
         dec_ctrl.act = rpn_pkg::ACT_END;
      end else if (push_ok && op_ok) begin
         dec_ctrl.act = rpn_pkg::ACT_PUSH_OP;
      end else if (push_ok) begin
         dec_ctrl.act = rpn_pkg::ACT_PUSH;
      end else if (op_ok) begin
         dec_ctrl.act = rpn_pkg::ACT_OP;
      end else begin
         dec_ctrl.act = rpn_pkg::ACT_NONE;
      end
   end

   // Next decode-stage state.
   always_comb begin
      accum_in  = accum_ff;
      digit_in  = digit_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      b_ctrl_in = b_ctrl_ff;
      if (acc) begin
         digit_in  = is_digit;
         b_ctrl_in = dec_ctrl;
         if (is_digit) begin
            accum_in = (accum_ff << 3) + (accum_ff << 1) + digit_val;
         end else if (push_try || is_end) begin
            accum_in = '0;
         end
         if (is_end) begin
            count_in = '0;
            err_in   = rpn_pkg::ERR_NONE;
         end else begin
            count_in = op_ok ? (c1 - ONE_C) : c1;
            err_in   = e2;
         end
      end else if (!b_stall) begin
         b_ctrl_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         digit_ff  <= 1'b0;
         count_ff  <= '0;
         err_ff    <= rpn_pkg::ERR_NONE;
         b_ctrl_ff <= '0;
      end else begin
         accum_ff  <= accum_in;
         digit_ff  <= digit_in;
         count_ff  <= count_in;
         err_ff    <= err_in;
         b_ctrl_ff <= b_ctrl_in;
      end
   end

   // Payload carried into the execute stage.
   always_ff @(posedge clock) begin
      if (acc) begin
         b_val_ff   <= accum_ff;
         b_waddr_ff <= waddr;
      end
   end

   // Stack memory with registered read and a bypass for a same-cycle spill.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[b_waddr_ff] <= tos_ff;
      end
      if (rd_en) begin
         rd_data_ff  <= stack_mem[raddr];
         fwd_data_ff <= tos_ff;
      end
   end

   // Operand select for the arithmetic unit.
   always_comb begin
      second = b_ctrl_ff.fwd ? fwd_data_ff : rd_data_ff;
      if (b_ctrl_ff.act == rpn_pkg::ACT_PUSH_OP) begin
         alu_lhs = tos_ff;
         alu_rhs = b_val_ff;
      end else begin
         alu_lhs = second;
         alu_rhs = tos_ff;
      end
   end

   rpn_alu u_alu (
      .op     (b_ctrl_ff.op),
      .lhs    (alu_lhs),
      .rhs    (alu_rhs),
      .result (alu_res)
   );

   // Top-of-stack update.
   always_comb begin
      case (b_ctrl_ff.act)
         rpn_pkg::ACT_PUSH:    tos_in = b_val_ff;
         rpn_pkg::ACT_PUSH_OP: tos_in = alu_res;
         rpn_pkg::ACT_OP:      tos_in = alu_res;
         default:              tos_in = tos_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
   end

   // Result register; an end transaction loads it once it is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (b_ctrl_ff.act == rpn_pkg::ACT_END && !b_stall) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ctrl_ff.act == rpn_pkg::ACT_END && !b_stall) begin
         rsp_status_ff <= b_ctrl_ff.status;
         if (b_ctrl_ff.pushed) begin
            rsp_value_ff <= b_val_ff;
         end else if (b_ctrl_ff.empty) begin
            rsp_value_ff <= '0;
         end else begin
            rsp_value_ff <= tos_ff;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   // The stack count never passes the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stack count beyond depth");

   // An end transaction leaves an empty stack and a clean status.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && is_end) |=> (count_ff == '0 && err_ff == rpn_pkg::ERR_NONE))
      else $error("end transaction did not clear the stack");

   // A read of the entry being spilled must take the bypass path.
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en && b_waddr_ff == raddr) |=> b_ctrl_ff.fwd)
      else $error("spill and read collided without bypass");

   // The first error of an expression is kept until its end.
   a_sticky_err: assert property (@(posedge clock) disable iff (reset)
      (err_ff != rpn_pkg::ERR_NONE && !(acc && is_end)) |=> err_ff == $past(err_ff))
      else $error("sticky error changed inside an expression");

endmodule

// File: hdl/rpn_alu.sv
// Arithmetic unit of the RPN evaluator: add, multiply, subtract modulo 2^32.
// Depends on rpn_pkg for the operator codes.
module rpn_alu (
   input  logic [1:0]  op,
   input  logic [31:0] lhs,
   input  logic [31:0] rhs,
   output logic [31:0] result
);

   logic [31:0] product;

   // Only the low word of the product is kept.
   assign product = lhs * rhs;

   // Operator select; subtraction is second operand minus top.
   always_comb begin
      case (op)
         rpn_pkg::OP_ADD: result = lhs + rhs;
         rpn_pkg::OP_MUL: result = product;
         rpn_pkg::OP_SUB: result = lhs - rhs;
         default:         result = lhs - rhs;
      endcase
   end

endmodule
